// ===== hdl/kts_pkg.sv =====
// shared constants, codes and divider interface types for the keyframe track sampler
package kts_pkg;

  localparam int MAX_KEYS_DEF = 256;
  localparam int NCOMP        = 9;
  localparam int VAL_W        = 32;
  localparam int DUR_W        = 31;
  localparam int ACT_W        = 2;
  localparam int STAT_W       = 3;
  localparam int CFG_IDX_W    = 2;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_TIME  = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_QUAT = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 2'd3;

  localparam int DIV_DW = 48;
  localparam int DIV_VW = 32;
  localparam int DIV_CW = $clog2(DIV_DW);

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } kts_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
    logic [DIV_VW-1:0] remainder;
  } kts_div_rsp_t;

endpackage

// ===== hdl/kts_div.sv =====
// shared restoring divider, one quotient bit per cycle
module kts_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kts_pkg::kts_div_req_t req_i,
  output kts_pkg::kts_div_rsp_t rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [kts_pkg::DIV_CW-1:0]    cnt_q;
  logic [kts_pkg::DIV_DW-1:0]    dq_q;
  logic [kts_pkg::DIV_VW-1:0]    rq_q;
  logic [kts_pkg::DIV_VW-1:0]    dv_q;
  logic [kts_pkg::DIV_VW:0]      tmp;
  logic                          ge;

  assign tmp = {rq_q, dq_q[kts_pkg::DIV_DW-1]};
  assign ge  = tmp >= {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == kts_pkg::DIV_CW'(kts_pkg::DIV_DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q <= req_i.dividend;
      dv_q <= req_i.divisor;
      rq_q <= '0;
    end else if (busy_q) begin
      dq_q <= {dq_q[kts_pkg::DIV_DW-2:0], ge};
      rq_q <= ge ? kts_pkg::DIV_VW'(tmp - {1'b0, dv_q}) : tmp[kts_pkg::DIV_VW-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dq_q;
  assign rsp_o.remainder = rq_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done longer than one cycle");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && dv_q != '0) |-> (rq_q < dv_q)) else $error("remainder not below divisor");

endmodule

// ===== hdl/keyframe_track_sampler_core.sv =====
// keyframe track sampler: key store, time resolve, search, blend and nlerp sequencer
// one item at a time; s_axis_tready is high only while idle
// clear goes straight to the output; append writes the key, rotation keys after a normalization pass
// sample time is set by the shared divider (modulo, weight, four normalizing divides),
// the 32-step square root and the search steps, each an S_BS and an S_BSW state
// reset clears the key count, state and config registers; datapath registers and key memories hold no reset value
module keyframe_track_sampler_core #(
  parameter int MAX_KEYS = kts_pkg::MAX_KEYS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // time_req, value_0 .. value_8
  input  logic [(kts_pkg::NCOMP+1)*32-1:0]   s_axis_tdata,
  // action
  input  logic [kts_pkg::ACT_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_0 .. out_8
  output logic [kts_pkg::NCOMP*32-1:0]       m_axis_tdata,
  // status
  output logic [kts_pkg::STAT_W-1:0]         m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic [kts_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kts_pkg::DUR_W-1:0]          cfg_wdata_i
);

  localparam int NC     = kts_pkg::NCOMP;
  localparam int AW     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW     = $clog2(MAX_KEYS + 1);
  localparam int VDEPTH = MAX_KEYS * NC;
  localparam int VAW    = $clog2(VDEPTH);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_APP   = 5'd1;
  localparam logic [4:0] S_WR    = 5'd2;
  localparam logic [4:0] S_RES   = 5'd3;
  localparam logic [4:0] S_MODW  = 5'd4;
  localparam logic [4:0] S_LOOK  = 5'd5;
  localparam logic [4:0] S_BS    = 5'd6;
  localparam logic [4:0] S_BSW   = 5'd7;
  localparam logic [4:0] S_WDIV  = 5'd8;
  localparam logic [4:0] S_WDW   = 5'd9;
  localparam logic [4:0] S_RD    = 5'd10;
  localparam logic [4:0] S_DOT   = 5'd11;
  localparam logic [4:0] S_BLEND = 5'd12;
  localparam logic [4:0] S_NINIT = 5'd13;
  localparam logic [4:0] S_NSH   = 5'd14;
  localparam logic [4:0] S_NSQ   = 5'd15;
  localparam logic [4:0] S_SQRT  = 5'd16;
  localparam logic [4:0] S_NDIV  = 5'd17;
  localparam logic [4:0] S_NDW   = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  function automatic logic [VAW-1:0] times9(input logic [AW-1:0] x);
    times9 = (VAW'(x) << 3) + VAW'(x);
  endfunction

  logic [4:0]                  state_q, state_d;
  logic [kts_pkg::ACT_W-1:0]   act_q, act_d;
  logic signed [31:0]          t_q, t_d;
  logic signed [31:0]          v_q [NC];
  logic signed [31:0]          v_d [NC];
  logic [31:0]                 res_q [NC];
  logic [31:0]                 res_d [NC];
  logic [kts_pkg::STAT_W-1:0]  status_q, status_d;
  logic [kts_pkg::DUR_W-1:0]   dur_q;
  logic                        loop_q, step_q, rot_q;
  logic [4:0]                  cnt_q, cnt_d;
  logic [CW-1:0]               count_q, count_d;
  logic signed [31:0]          first_q, first_d, last_q, last_d;
  logic signed [31:0]          tres_q, tres_d;
  logic [AW-1:0]               lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic signed [31:0]          t0_q, t0_d, t1_q, t1_d;
  logic [15:0]                 w_q, w_d;
  logic signed [31:0]          kv_q [18];
  logic signed [31:0]          kv_d [18];
  logic signed [67:0]          p_q;
  logic signed [67:0]          acc_q, acc_d;
  logic                        dneg_q, dneg_d;
  logic signed [33:0]          q_q [4];
  logic signed [33:0]          q_d [4];
  logic [33:0]                 nm_q [4];
  logic [33:0]                 nm_d [4];
  logic [3:0]                  sg_q, sg_d;
  logic [63:0]                 x_q, x_d, r_q, r_d;
  logic [4:0]                  bi_q, bi_d;
  logic [VAW-1:0]              rbase_q, rbase_d;
  logic                        copy_q, copy_d;
  logic                        nsrc_q, nsrc_d;
  logic signed [31:0]          ap_q, ap_d;

  logic signed [33:0]          mul_a, mul_b;
  kts_pkg::kts_div_req_t       div_req;
  kts_pkg::kts_div_rsp_t       div_rsp;

  logic [31:0]                 tm_mem [MAX_KEYS];
  logic [31:0]                 vm_mem [VDEPTH];
  logic                        tm_we, vm_we;
  logic [AW-1:0]               tm_waddr, tm_raddr;
  logic [VAW-1:0]              vm_waddr, vm_raddr;
  logic [31:0]                 tm_wdata, vm_wdata, tm_rdata_q, vm_rdata_q;

  logic signed [31:0]          dur_s;
  logic [31:0]                 tabs;
  logic [CW-1:0]               cm1;
  logic signed [33:0]          bsel, diff, src;
  logic signed [67:0]          pt, yr, blended;
  logic [33:0]                 orv;
  logic [63:0]                 bitv, rb;
  logic [31:0]                 qv;
  logic [3:0]                  kidx;

  kts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (tm_we) tm_mem[tm_waddr] <= tm_wdata;
    tm_rdata_q <= tm_mem[tm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vm_we) vm_mem[vm_waddr] <= vm_wdata;
    vm_rdata_q <= vm_mem[vm_raddr];
  end

  assign dur_s = $signed({1'b0, dur_q});
  assign tabs  = t_q[31] ? 32'(-t_q) : 32'(t_q);
  assign cm1   = count_q - CW'(1);
  assign orv   = nm_q[0] | nm_q[1] | nm_q[2] | nm_q[3];
  assign bitv  = 64'd1 << {bi_q, 1'b0};
  assign rb    = r_q + bitv;
  assign qv    = div_rsp.quotient[31:0];
  assign kidx  = cnt_q[3:0] - 4'd1;

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    t_d      = t_q;
    v_d      = v_q;
    res_d    = res_q;
    status_d = status_q;
    cnt_d    = cnt_q;
    count_d  = count_q;
    first_d  = first_q;
    last_d   = last_q;
    tres_d   = tres_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    t0_d     = t0_q;
    t1_d     = t1_q;
    w_d      = w_q;
    kv_d     = kv_q;
    acc_d    = acc_q;
    dneg_d   = dneg_q;
    q_d      = q_q;
    nm_d     = nm_q;
    sg_d     = sg_q;
    x_d      = x_q;
    r_d      = r_q;
    bi_d     = bi_q;
    rbase_d  = rbase_q;
    copy_d   = copy_q;
    nsrc_d   = nsrc_q;
    ap_d     = ap_q;
    mul_a    = '0;
    mul_b    = '0;
    div_req  = '0;
    tm_we    = 1'b0;
    vm_we    = 1'b0;
    tm_waddr = count_q[AW-1:0];
    tm_wdata = 32'(t_q);
    tm_raddr = mid_q;
    vm_waddr = rbase_q + VAW'(cnt_q);
    vm_wdata = 32'(v_q[cnt_q[3:0]]);
    vm_raddr = rbase_q + VAW'(cnt_q);
    bsel     = '0;
    diff     = '0;
    src      = '0;
    pt       = p_q[67] ? ((p_q + 68'sd3) >>> 2) : (p_q >>> 2);
    yr       = p_q + 68'sd32768;
    blended  = 68'(ap_q) + (yr >>> 16);

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          act_d    = s_axis_tuser;
          t_d      = $signed(s_axis_tdata[31:0]);
          for (int k = 0; k < NC; k++) begin
            v_d[k]   = $signed(s_axis_tdata[32*(k+1) +: 32]);
            res_d[k] = '0;
          end
          status_d = kts_pkg::ST_OK;
          case (s_axis_tuser)
            kts_pkg::ACT_CLEAR: begin
              count_d = '0;
              state_d = S_OUT;
            end
            kts_pkg::ACT_APPEND: state_d = S_APP;
            kts_pkg::ACT_SAMPLE: state_d = S_RES;
            default:             state_d = S_OUT;
          endcase
        end
      end

      S_APP: begin
        rbase_d = times9(count_q[AW-1:0]);
        cnt_d   = '0;
        if (t_q[31] || t_q > dur_s || (count_q != '0 && t_q <= last_q)) begin
          status_d = kts_pkg::ST_BAD_TIME;
          state_d  = S_OUT;
        end else if (rot_q && v_q[0] == '0 && v_q[1] == '0 && v_q[2] == '0 &&
                     v_q[3] == '0) begin
          status_d = kts_pkg::ST_ZERO_QUAT;
          state_d  = S_OUT;
        end else if (count_q == CW'(MAX_KEYS)) begin
          status_d = kts_pkg::ST_FULL;
          state_d  = S_OUT;
        end else if (rot_q) begin
          nsrc_d  = 1'b0;
          state_d = S_NINIT;
        end else begin
          state_d = S_WR;
        end
      end

      S_WR: begin
        vm_we = 1'b1;
        tm_we = (cnt_q == '0);
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(NC - 1)) begin
          count_d = count_q + CW'(1);
          last_d  = t_q;
          if (count_q == '0) first_d = t_q;
          state_d = S_OUT;
        end
      end

      S_RES: begin
        if (dur_q == '0) begin
          tres_d  = '0;
          state_d = S_LOOK;
        end else if (!loop_q) begin
          tres_d  = t_q[31] ? 32'sd0 : ((t_q > dur_s) ? dur_s : t_q);
          state_d = S_LOOK;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = kts_pkg::DIV_DW'(tabs);
          div_req.divisor  = {1'b0, dur_q};
          state_d          = S_MODW;
        end
      end

      S_MODW: begin
        if (div_rsp.done) begin
          tres_d  = (t_q[31] && div_rsp.remainder != '0) ?
                    $signed({1'b0, dur_q} - div_rsp.remainder) :
                    $signed(div_rsp.remainder);
          state_d = S_LOOK;
        end
      end

      S_LOOK: begin
        cnt_d  = '0;
        copy_d = 1'b1;
        if (count_q == '0) begin
          for (int k = 0; k < NC; k++) res_d[k] = 32'(v_q[k]);
          state_d = S_OUT;
        end else if (tres_q <= first_q) begin
          rbase_d = '0;
          state_d = S_RD;
        end else if (tres_q >= last_q) begin
          rbase_d = times9(cm1[AW-1:0]);
          state_d = S_RD;
        end else begin
          lo_d    = '0;
          hi_d    = cm1[AW-1:0];
          t0_d    = first_q;
          t1_d    = last_q;
          state_d = S_BS;
        end
      end

      S_BS: begin
        if (hi_q - lo_q == AW'(1)) begin
          cnt_d   = '0;
          rbase_d = times9(lo_q);
          if (step_q) begin
            copy_d  = 1'b1;
            state_d = S_RD;
          end else begin
            state_d = S_WDIV;
          end
        end else begin
          mid_d   = AW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
          tm_raddr = mid_d;
          state_d = S_BSW;
        end
      end

      S_BSW: begin
        if ($signed(tm_rdata_q) <= tres_q) begin
          lo_d = mid_q;
          t0_d = $signed(tm_rdata_q);
        end else begin
          hi_d = mid_q;
          t1_d = $signed(tm_rdata_q);
        end
        state_d = S_BS;
      end

      S_WDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {32'(tres_q - t0_q), 16'd0};
        div_req.divisor  = 32'(t1_q - t0_q);
        state_d          = S_WDW;
      end

      S_WDW: begin
        if (div_rsp.done) begin
          w_d     = div_rsp.quotient[15:0];
          copy_d  = 1'b0;
          cnt_d   = '0;
          state_d = S_RD;
        end
      end

      S_RD: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q != '0) begin
          for (int i = 0; i < 17; i++) kv_d[i] = kv_q[i+1];
          kv_d[17] = $signed(vm_rdata_q);
        end
        if (cnt_q == (copy_q ? 5'(NC) : 5'(2 * NC))) begin
          cnt_d = '0;
          acc_d = '0;
          if (copy_q) begin
            for (int k = 0; k < NC; k++) res_d[k] = 32'(kv_d[NC+k]);
            state_d = S_OUT;
          end else begin
            state_d = rot_q ? S_DOT : S_BLEND;
          end
        end
      end

      S_DOT: begin
        cnt_d = cnt_q + 5'd1;
        mul_a = 34'(kv_q[0]);
        mul_b = 34'(kv_q[NC]);
        if (cnt_q < 5'(NC)) begin
          for (int i = 0; i < NC - 1; i++) begin
            kv_d[i]    = kv_q[i+1];
            kv_d[NC+i] = kv_q[NC+i+1];
          end
          kv_d[NC-1]   = kv_q[0];
          kv_d[2*NC-1] = kv_q[NC];
        end
        if (cnt_q >= 5'd1 && cnt_q <= 5'd4) acc_d = acc_q + pt;
        if (cnt_q == 5'(NC)) begin
          dneg_d  = acc_q[67];
          cnt_d   = '0;
          state_d = S_BLEND;
        end
      end

      S_BLEND: begin
        cnt_d = cnt_q + 5'd1;
        bsel  = (rot_q && cnt_q < 5'd4 && dneg_q) ? -34'(kv_q[NC]) : 34'(kv_q[NC]);
        diff  = bsel - 34'(kv_q[0]);
        mul_a = diff;
        mul_b = $signed({18'd0, w_q});
        ap_d  = kv_q[0];
        if (cnt_q < 5'(NC)) begin
          for (int i = 0; i < NC - 1; i++) begin
            kv_d[i]    = kv_q[i+1];
            kv_d[NC+i] = kv_q[NC+i+1];
          end
          kv_d[NC-1]   = kv_q[0];
          kv_d[2*NC-1] = kv_q[NC];
        end
        if (cnt_q != '0) begin
          if (rot_q && kidx < 4'd4) q_d[kidx[1:0]] = blended[33:0];
          else res_d[kidx] = blended[31:0];
        end
        if (cnt_q == 5'(NC)) begin
          nsrc_d  = 1'b1;
          state_d = rot_q ? S_NINIT : S_OUT;
        end
      end

      S_NINIT: begin
        for (int i = 0; i < 4; i++) begin
          src      = nsrc_q ? q_q[i] : 34'(v_q[i]);
          sg_d[i]  = src[33];
          nm_d[i]  = src[33] ? 34'(-src) : 34'(src);
        end
        if (nsrc_q && q_q[0] == '0 && q_q[1] == '0 && q_q[2] == '0 && q_q[3] == '0) begin
          for (int i = 0; i < 4; i++) res_d[i] = '0;
          state_d = S_OUT;
        end else begin
          state_d = S_NSH;
        end
      end

      S_NSH: begin
        if (orv[33:30] != '0) begin
          for (int i = 0; i < 4; i++) nm_d[i] = nm_q[i] >> 1;
        end else if (!orv[29]) begin
          for (int i = 0; i < 4; i++) nm_d[i] = nm_q[i] << 1;
        end else begin
          cnt_d   = '0;
          acc_d   = '0;
          state_d = S_NSQ;
        end
      end

      S_NSQ: begin
        cnt_d = cnt_q + 5'd1;
        mul_a = $signed(nm_q[cnt_q[1:0]]);
        mul_b = $signed(nm_q[cnt_q[1:0]]);
        if (cnt_q != '0) acc_d = acc_q + p_q;
        if (cnt_q == 5'd4) begin
          x_d     = acc_d[63:0];
          r_d     = '0;
          bi_d    = 5'd31;
          state_d = S_SQRT;
        end
      end

      S_SQRT: begin
        if (x_q >= rb) begin
          x_d = x_q - rb;
          r_d = (r_q >> 1) + bitv;
        end else begin
          r_d = r_q >> 1;
        end
        bi_d = bi_q - 5'd1;
        if (bi_q == '0) begin
          cnt_d   = '0;
          state_d = S_NDIV;
        end
      end

      S_NDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {nm_q[cnt_q[1:0]][31:0], 16'd0} + kts_pkg::DIV_DW'(r_q >> 1);
        div_req.divisor  = r_q[31:0];
        state_d          = S_NDW;
      end

      S_NDW: begin
        if (div_rsp.done) begin
          if (nsrc_q) res_d[cnt_q[3:0]] = sg_q[cnt_q[1:0]] ? -qv : qv;
          else v_d[cnt_q[3:0]] = $signed(sg_q[cnt_q[1:0]] ? -qv : qv);
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == 5'd3) begin
            cnt_d   = '0;
            state_d = nsrc_q ? S_OUT : S_WR;
          end else begin
            state_d = S_NDIV;
          end
        end
      end

      S_OUT: begin
        if (m_axis_tready) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      dur_q   <= '0;
      loop_q  <= 1'b0;
      step_q  <= 1'b0;
      rot_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kts_pkg::REG_DURATION: dur_q  <= cfg_wdata_i;
          kts_pkg::REG_LOOP:     loop_q <= cfg_wdata_i[0];
          kts_pkg::REG_STEP:     step_q <= cfg_wdata_i[0];
          kts_pkg::REG_ROTATION: rot_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    t_q      <= t_d;
    v_q      <= v_d;
    res_q    <= res_d;
    status_q <= status_d;
    first_q  <= first_d;
    last_q   <= last_d;
    tres_q   <= tres_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    t0_q     <= t0_d;
    t1_q     <= t1_d;
    w_q      <= w_d;
    kv_q     <= kv_d;
    p_q      <= mul_a * mul_b;
    acc_q    <= acc_d;
    dneg_q   <= dneg_d;
    q_q      <= q_d;
    nm_q     <= nm_d;
    sg_q     <= sg_d;
    x_q      <= x_d;
    r_q      <= r_d;
    bi_q     <= bi_d;
    rbase_q  <= rbase_d;
    copy_q   <= copy_d;
    nsrc_q   <= nsrc_d;
    ap_q     <= ap_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tuser  = status_q;

  for (genvar k = 0; k < NC; k++) begin : g_out
    assign m_axis_tdata[32*k +: 32] = res_q[k];
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while a result waits");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_KEYS)) else $error("key count beyond store size");
  a_status_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status_q != kts_pkg::ST_OK) |-> (act_q == kts_pkg::ACT_APPEND))
    else $error("error status on a non-append item");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q) && count_q != '0) |-> ($past(state_q) == S_WR))
    else $error("key count moved outside a store write");

endmodule
